// ----- hdl/bdcd_pkg.sv -----
package bdcd_pkg;

  localparam int QueueDepth  = 32;
  localparam int HandleCount = 1024;
  localparam int IdxW        = $clog2(QueueDepth);
  localparam int CntW        = $clog2(QueueDepth + 1);
  localparam int MarkW       = $clog2(HandleCount);
  localparam int FifoDepth   = 4;

  typedef enum logic [2:0] {
    MODE_PUSH  = 3'd0,
    MODE_PUSHB = 3'd1,
    MODE_POP   = 3'd2,
    MODE_FLKP  = 3'd3,
    MODE_FLALL = 3'd4,
    MODE_STATS = 3'd5
  } mode_e;

  localparam logic [2:0] T_REP   = 3'd0;
  localparam logic [2:0] T_DEL   = 3'd1;
  localparam logic [2:0] T_FLUSH = 3'd2;
  localparam logic [2:0] T_DEFER = 3'd3;
  localparam logic [2:0] T_SYNC  = 3'd4;
  localparam logic [2:0] T_SYNC0 = 3'd5;
  localparam logic [2:0] T_SYNC1 = 3'd6;
  localparam logic [2:0] T_BAD   = 3'd7;

  localparam logic [2:0] K_ACC   = 3'd0;
  localparam logic [2:0] K_IGN   = 3'd1;
  localparam logic [2:0] K_POP   = 3'd2;
  localparam logic [2:0] K_EMPTY = 3'd3;
  localparam logic [2:0] K_REL   = 3'd4;
  localparam logic [2:0] K_STATS = 3'd5;
  localparam logic [2:0] K_FULL  = 3'd6;

  localparam logic CFG_MAX = 1'b0;
  localparam logic CFG_SRV = 1'b1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  ctype;
    logic        item;
    logic [9:0]  handle;
    logic [31:0] tag;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  otype;
    logic        ohas;
    logic [9:0]  ohandle;
    logic [31:0] otag;
    logic [31:0] otime;
    logic [5:0]  qlen;
    logic [63:0] recyc;
    logic [31:0] oldest;
    logic [31:0] youngest;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MARK, S_FLUSH, S_FLREAD, S_STATS, S_EMIT
  } state_e;

endpackage

// ----- hdl/bdcd_front.sv -----
module bdcd_front import bdcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] mode_i,
  input  logic [2:0] cmd_type_i,
  input  logic       has_item_i,
  input  logic [9:0] item_handle_i,
  input  logic [31:0] entry_tag_i,
  input  logic [31:0] now_i,
  input  logic       srv_i,
  output logic       vld_o,
  output cmd_t       cmd_o,
  input  logic       rdy_i
);
  localparam int PW = $clog2(FifoDepth);
  cmd_t mem_q [FifoDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0] cnt_q;
  cmd_t c;
  logic wr, rd;

  // classify: mode 0 non-rep items dropped, disconnected rep/sync and bad types ignored
  always_comb begin
    c.mode   = mode_i;
    c.ctype  = cmd_type_i;
    c.item   = has_item_i;
    c.handle = item_handle_i;
    c.tag    = entry_tag_i;
    c.now    = now_i;
    if (mode_i == MODE_PUSH) begin
      if (cmd_type_i != T_REP) c.item = 1'b0;
      if (!srv_i && (cmd_type_i == T_REP || cmd_type_i == T_SYNC)) c.ctype = T_BAD;
    end
  end

  assign full  = cnt_q == (PW+1)'(FifoDepth);
  assign wr    = push && !full;
  assign vld_o = cnt_q != '0;
  assign rd    = vld_o && rdy_i;
  assign cmd_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(FifoDepth)) else $error("fifo overflow");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |=> !(cnt_q == '0)) else $error("full to empty");
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd |-> vld_o) else $error("read empty");
`endif
endmodule

// ----- hdl/bdcd_back.sv -----
module bdcd_back import bdcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vld_i,
  input  cmd_t       cmd_i,
  output logic       rdy_o,
  input  logic [5:0] maxe_i,
  output logic       res_vld_o,
  output res_t       res_o,
  input  logic       res_rdy_i
);
  logic [3:0]  kind_m [QueueDepth];
  logic [9:0]  hnd_m  [QueueDepth];
  logic [31:0] tag_m  [QueueDepth];
  logic [31:0] tim_m  [QueueDepth];
  logic        mark_m [HandleCount];

  state_e st_q, st_d;
  cmd_t  c_q, c_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] cnt_q, cnt_d, i_q, i_d, kept_q, kept_d, n_q, n_d;
  logic [CntW-1:0] plain_q, plain_d;
  logic [63:0] rec_q, rec_d;
  res_t r_q, r_d;
  logic rv_q, rv_d;
  logic mk_q;
  logic [31:0] old_q, old_d;
  logic found_q, found_d;
  logic clr_q;
  logic [MarkW-1:0] cidx_q;

  logic [CntW-1:0] lim;
  logic [IdxW-1:0] rp, wp, mp;
  logic [3:0]  rk_q;
  logic [9:0]  rh_q;
  logic [31:0] rt_q, rm_q;
  logic [3:0]  pk;
  logic [9:0]  ph;
  logic [31:0] pt, pm;
  logic we, mwe, mwv;
  logic [MarkW-1:0] mwa, mra;
  logic take;

  always_comb begin
    lim = maxe_i[CntW-1:0];
    if (maxe_i == '0) lim = CntW'(1);
    if (maxe_i > 6'(QueueDepth)) lim = CntW'(QueueDepth);
  end

  assign mra = (st_q == S_IDLE) ? cmd_i.handle[MarkW-1:0] : c_q.handle[MarkW-1:0];

  // single read port of the slot store, registered
  always_ff @(posedge clk_i) begin
    rk_q <= kind_m[rp];
    rh_q <= hnd_m[rp];
    rt_q <= tag_m[rp];
    rm_q <= tim_m[rp];
    mk_q <= mark_m[mra];
    if (we) begin
      kind_m[wp] <= pk; hnd_m[wp] <= ph; tag_m[wp] <= pt; tim_m[wp] <= pm;
    end
    if (mwe) mark_m[mwa] <= mwv;
  end

  assign take = rv_q && res_rdy_i;
  assign res_vld_o = rv_q;
  assign res_o = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; head_q <= '0; cnt_q <= '0; rec_q <= '0; rv_q <= 1'b0;
      i_q <= '0; kept_q <= '0; n_q <= '0; found_q <= 1'b0; plain_q <= '0;
      clr_q <= 1'b1; cidx_q <= '0;
    end else begin
      st_q <= st_d; head_q <= head_d; cnt_q <= cnt_d; rec_q <= rec_d; rv_q <= rv_d;
      i_q <= i_d; kept_q <= kept_d; n_q <= n_d; found_q <= found_d; plain_q <= plain_d;
      if (clr_q) begin
        cidx_q <= cidx_q + 1'b1;
        if (&cidx_q) clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d; r_q <= r_d; old_q <= old_d;
  end

  always_comb begin
    logic rel, empty_r, np, hp;
    st_d = st_q; c_d = c_q; head_d = head_q; cnt_d = cnt_q; rec_d = rec_q;
    i_d = i_q; kept_d = kept_q; n_d = n_q; found_d = found_q; old_d = old_q;
    plain_d = plain_q;
    r_d = r_q; rv_d = rv_q && !res_rdy_i;
    rdy_o = 1'b0; we = 1'b0; mwe = 1'b0; mwv = 1'b0;
    mwa = c_q.handle[MarkW-1:0];
    wp = head_q; rp = head_q;
    pk = {c_q.item, c_q.ctype}; ph = c_q.handle; pt = c_q.tag; pm = c_q.now;
    rel = 1'b0;
    empty_r = !rv_q || res_rdy_i;
    // plain entries are the ones a keep-plain flush leaves in place
    np = !c_q.item && !(c_q.ctype inside {T_SYNC, T_SYNC0, T_SYNC1});
    hp = !rk_q[3] && !(rk_q[2:0] inside {T_SYNC, T_SYNC0, T_SYNC1});
    case (st_q)
      S_IDLE: begin
        if (clr_q) begin
          mwe = 1'b1; mwv = 1'b0; mwa = cidx_q;
        end else begin
          rdy_o = 1'b1;
          if (vld_i) begin
            c_d = cmd_i; st_d = S_MARK;
          end
        end
      end
      S_MARK: begin
        // head slot (rk_q) and mark (mk_q) are now registered
        if (empty_r) begin
          r_d = '0; r_d.last = 1'b1; rv_d = 1'b1; st_d = S_IDLE;
          case (c_q.mode)
            MODE_PUSH, MODE_PUSHB: begin
              if (c_q.ctype == T_BAD || (c_q.item && mk_q)) r_d.kind = K_IGN;
              else if (c_q.mode == MODE_PUSHB || c_q.ctype == T_SYNC0 ||
                       c_q.ctype == T_SYNC1) begin
                if (cnt_q >= CntW'(QueueDepth)) r_d.kind = K_FULL;
                else begin
                  head_d = (head_q == '0) ? IdxW'(QueueDepth-1) : head_q - 1'b1;
                  wp = head_d; we = 1'b1; cnt_d = cnt_q + 1'b1; r_d.kind = K_ACC;
                  mwe = c_q.item; mwv = 1'b1;
                  plain_d = plain_q + CntW'(np);
                end
              end else begin
                if (cnt_q >= lim) begin
                  rec_d = rec_q + 64'd1;
                  head_d = (head_q == IdxW'(QueueDepth-1)) ? '0 : head_q + 1'b1;
                  wp = IdxW'((32'(head_q) + 32'(cnt_q)) % QueueDepth);
                  if (rk_q[3]) begin
                    // old head mark clear now, new mark next cycle via S_EMIT
                    mwe = 1'b1; mwv = 1'b0; mwa = rh_q[MarkW-1:0];
                    st_d = S_EMIT;
                  end
                  cnt_d = cnt_q;
                  plain_d = plain_q - CntW'(hp) + CntW'(np);
                end else begin
                  wp = IdxW'((32'(head_q) + 32'(cnt_q)) % QueueDepth);
                  cnt_d = cnt_q + 1'b1;
                  plain_d = plain_q + CntW'(np);
                end
                we = 1'b1; r_d.kind = K_ACC;
                if (st_d != S_EMIT) begin
                  mwe = c_q.item; mwv = 1'b1;
                end
              end
            end
            MODE_POP: begin
              if (cnt_q == '0) r_d.kind = K_EMPTY;
              else begin
                r_d.kind = K_POP; r_d.otype = rk_q[2:0]; r_d.ohas = rk_q[3];
                r_d.ohandle = rh_q; r_d.otag = rt_q; r_d.otime = rm_q;
                mwe = rk_q[3]; mwv = 1'b0; mwa = rh_q[MarkW-1:0];
                head_d = (head_q == IdxW'(QueueDepth-1)) ? '0 : head_q + 1'b1;
                cnt_d = cnt_q - 1'b1;
                plain_d = plain_q - CntW'(hp);
              end
            end
            MODE_FLKP, MODE_FLALL: begin
              rv_d = rv_q && !res_rdy_i; i_d = '0; kept_d = '0; n_d = cnt_q;
              st_d = S_FLREAD;
            end
            MODE_STATS: begin
              rv_d = rv_q && !res_rdy_i; i_d = '0; found_d = 1'b0; old_d = '0;
              st_d = S_STATS;
            end
            default: r_d.kind = K_IGN;
          endcase
          r_d.qlen = 6'(cnt_d); r_d.recyc = rec_d;
        end
      end
      S_EMIT: begin
        mwe = c_q.item; mwv = 1'b1; st_d = S_IDLE;
      end
      S_FLREAD: begin
        // issue read of entry i
        rp = IdxW'((32'(head_q) + 32'(i_q)) % QueueDepth);
        if (i_q == n_q) begin
          if (empty_r) begin
            r_d = '0; r_d.kind = K_ACC; r_d.qlen = 6'(kept_q); r_d.recyc = rec_q;
            r_d.last = 1'b1; rv_d = 1'b1; cnt_d = kept_q; plain_d = kept_q;
            st_d = S_IDLE;
          end
        end else st_d = S_FLUSH;
      end
      S_FLUSH: begin
        rp = IdxW'((32'(head_q) + 32'(i_q)) % QueueDepth);
        rel = c_q.mode == MODE_FLALL || rk_q[2:0] == T_SYNC || rk_q[2:0] == T_SYNC0 ||
              rk_q[2:0] == T_SYNC1 || rk_q[3];
        if (rel && rk_q[3]) begin
          if (empty_r) begin
            r_d = '0; r_d.kind = K_REL; r_d.otype = rk_q[2:0]; r_d.ohas = 1'b1;
            r_d.ohandle = rh_q; r_d.otag = rt_q; r_d.otime = rm_q;
            r_d.qlen = (c_q.mode == MODE_FLALL) ? '0 : 6'(plain_q);
            r_d.recyc = rec_q; r_d.last = 1'b0; rv_d = 1'b1;
            mwe = 1'b1; mwv = 1'b0; mwa = rh_q[MarkW-1:0];
            i_d = i_q + 1'b1; st_d = S_FLREAD;
          end
        end else begin
          if (!rel) begin
            wp = IdxW'((32'(head_q) + 32'(kept_q)) % QueueDepth);
            pk = rk_q; ph = rh_q; pt = rt_q; pm = rm_q; we = 1'b1;
            kept_d = kept_q + 1'b1;
          end
          i_d = i_q + 1'b1; st_d = S_FLREAD;
        end
      end
      S_STATS: begin
        // read entry i; rk_q holds the result for entry i-1
        if (i_q != '0 && !found_q && rk_q[2:0] != T_DEFER) begin
          found_d = 1'b1; old_d = c_q.now - rm_q;
        end
        // at the end keep rereading the tail so a stall leaves rk_q unchanged
        rp = IdxW'((32'(head_q) + 32'(i_q) - ((i_q == cnt_q) ? 32'd1 : 32'd0)) % QueueDepth);
        if (i_q == cnt_q) begin
          if (empty_r) begin
            r_d = '0; r_d.kind = K_STATS; r_d.qlen = 6'(cnt_q); r_d.recyc = rec_q;
            r_d.last = 1'b1; rv_d = 1'b1; st_d = S_IDLE;
            r_d.oldest = found_d ? old_d : '0;
            if (cnt_q != '0 && rk_q[2:0] != T_DEFER) r_d.youngest = c_q.now - rm_q;
          end else i_d = i_q;
        end else i_d = i_q + 1'b1;
      end
      default: st_d = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth)) else $error("count overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && !res_rdy_i |=> rv_q && $stable(r_q)) else $error("result lost");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy_o |-> st_q == S_IDLE) else $error("ready while busy");
`endif
endmodule

// ----- hdl/bounded_dedup_command_deque_core.sv -----
// Push, pop and ignored commands pass from the command queue into a command register,
// read the head slot and item mark, then register their result; flush and stats read
// each entry in turn. A new command is taken only when the last one is done.
// A 4-entry command queue and an output register decouple the two sides.
// Reset (async, active low) clears pointers and counts, then a pass over all 1024 item
// marks clears them before the first command is taken.
module bounded_dedup_command_deque_core import bdcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  mode_i,
  input  logic [2:0]  cmd_type_i,
  input  logic        has_item_i,
  input  logic [9:0]  item_handle_i,
  input  logic [31:0] entry_tag_i,
  input  logic [31:0] now_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [2:0]  out_type_o,
  output logic        out_has_item_o,
  output logic [9:0]  out_handle_o,
  output logic [31:0] out_tag_o,
  output logic [31:0] out_time_o,
  output logic [5:0]  queue_length_o,
  output logic [63:0] recycled_total_o,
  output logic [31:0] oldest_age_o,
  output logic [31:0] youngest_age_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [5:0]  cfg_data_i
);
  logic [5:0] maxe_q;
  logic srv_q;
  logic v;
  logic rdy;
  cmd_t c;
  res_t r;
  logic rv;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxe_q <= 6'd32; srv_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX: maxe_q <= cfg_data_i;
        CFG_SRV: srv_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  bdcd_front u_front (
    .clk_i, .rst_ni, .push, .full, .mode_i, .cmd_type_i, .has_item_i, .item_handle_i,
    .entry_tag_i, .now_i, .srv_i(srv_q), .vld_o(v), .cmd_o(c), .rdy_i(rdy)
  );

  bdcd_back u_back (
    .clk_i, .rst_ni, .vld_i(v), .cmd_i(c), .rdy_o(rdy), .maxe_i(maxe_q),
    .res_vld_o(rv), .res_o(r), .res_rdy_i(pop)
  );

  assign empty = !rv;
  assign kind_o = r.kind;
  assign out_type_o = r.otype;
  assign out_has_item_o = r.ohas;
  assign out_handle_o = r.ohandle;
  assign out_tag_o = r.otag;
  assign out_time_o = r.otime;
  assign queue_length_o = r.qlen;
  assign recycled_total_o = r.recyc;
  assign oldest_age_o = r.oldest;
  assign youngest_age_o = r.youngest;
  assign last_o = r.last;
endmodule
